### rtl/core/positional_list_table_defines.svh
// ----------------------------------------------------------------------------
// positional_list_table_defines
// assertion macros used by the positional list table rtl
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_TABLE_DEFINES_SVH
`define POSITIONAL_LIST_TABLE_DEFINES_SVH

// same-cycle implication, checked on i_clk, off during reset
`define PLT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on i_clk, off during reset
`define PLT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/plt_pkg.sv
// ----------------------------------------------------------------------------
// plt_pkg
// shared constants, codes and types of the positional list table
// ----------------------------------------------------------------------------
package plt_pkg;

    // list geometry
    localparam int CAPACITY = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int FILL_W   = 6;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int OP_W     = 3;

    // request codes
    localparam logic [OP_W-1:0] OP_GET    = 3'd0;
    localparam logic [OP_W-1:0] OP_LOCATE = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    // cell commands
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_INS   = 3'd1;
    localparam logic [2:0] CMD_DEL   = 3'd2;
    localparam logic [2:0] CMD_LOAD  = 3'd3;
    localparam logic [2:0] CMD_SHIFT = 3'd4;

    // command broadcast to every cell
    typedef struct packed {
        logic [2:0]        code;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
    } t_cell_cmd;

endpackage

### rtl/core/positional_list_table.sv
// ----------------------------------------------------------------------------
// positional_list_table
// ordered list of signed 32-bit entries held in a row of shifting cells
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser op, tdata position, value
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser status, tdata results
//
//  insert, clear and every error case: result registered on transfer, no scan
//  get and delete at position p: the tap chain walks one entry per cycle past
//  the head cell until entry p reaches it; locate: until a match or the end
//  reset clears the fill count, state and valid flags; entries are not cleared
//  a result waiting on m_axis does not stop the next request; a second finished
//  result is parked in a hold register and stalls s_axis until the first is taken
// ----------------------------------------------------------------------------
`include "positional_list_table_defines.svh"

module positional_list_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // position[5:0], value[37:6], zero pad
    input  logic [2:0]  s_axis_tuser,   // op[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // value_out[31:0], found_position[37:32],
                                        // fill_level[43:38], is_empty[44], zero pad
    output logic [0:0]  m_axis_tuser    // status[0]
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    typedef struct packed {
        logic                        status;
        logic [plt_pkg::DATA_W-1:0]  value_out;
        logic [plt_pkg::FILL_W-1:0]  found;
        logic [plt_pkg::FILL_W-1:0]  fill;
        logic                        empty;
    } t_result;

    logic [1:0]                     r_state, n_state;
    logic [plt_pkg::FILL_W-1:0]     r_fill, n_fill;
    logic [plt_pkg::IDX_W-1:0]      r_k, n_k;
    logic [plt_pkg::IDX_W-1:0]      r_idx, n_idx;
    logic [plt_pkg::OP_W-1:0]       r_op, n_op;
    logic [plt_pkg::DATA_W-1:0]     r_val, n_val;
    logic                           r_hold_valid, n_hold_valid;
    t_result                        r_hold, n_hold;
    logic                           r_m_tvalid;
    t_result                        r_m_res;

    logic                           w_accept;
    logic                           w_slot_free;
    logic                           w_done;
    t_result                        w_res;
    plt_pkg::t_cell_cmd             w_cmd;

    logic [plt_pkg::OP_W-1:0]       w_op;
    logic [plt_pkg::POS_W-1:0]      w_pos;
    logic [plt_pkg::DATA_W-1:0]     w_in_val;
    logic                           w_rd_ok;
    logic                           w_ins_ok;
    logic [plt_pkg::FILL_W-1:0]     w_k_next;

    logic [plt_pkg::DATA_W-1:0]     w_cval  [plt_pkg::CAPACITY];
    logic [plt_pkg::DATA_W-1:0]     w_ctap  [plt_pkg::CAPACITY];
    logic [plt_pkg::DATA_W-1:0]     w_left  [plt_pkg::CAPACITY];
    logic [plt_pkg::DATA_W-1:0]     w_right [plt_pkg::CAPACITY];
    logic [plt_pkg::DATA_W-1:0]     w_rtap  [plt_pkg::CAPACITY];

    // input unpacking and position checks
    assign w_op     = s_axis_tuser;
    assign w_pos    = s_axis_tdata[5:0];
    assign w_in_val = s_axis_tdata[37:6];
    assign w_rd_ok  = (w_pos != '0) && (w_pos <= r_fill);
    assign w_ins_ok = (r_fill < plt_pkg::FILL_W'(plt_pkg::CAPACITY)) && (w_pos != '0)
                      && ({1'b0, w_pos} <= ({1'b0, r_fill} + 7'd1));
    assign w_k_next = {1'b0, r_k} + 6'd1;

    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_slot_free   = !r_m_tvalid || m_axis_tready;

    // request control and cell commands
    always_comb begin
        n_state      = r_state;
        n_fill       = r_fill;
        n_k          = r_k;
        n_idx        = r_idx;
        n_op         = r_op;
        n_val        = r_val;
        w_done       = 1'b0;
        w_res        = '0;
        w_cmd.code   = plt_pkg::CMD_NONE;
        w_cmd.idx    = r_idx;
        w_cmd.value  = r_val;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op  = w_op;
                    n_val = w_in_val;
                    n_idx = plt_pkg::IDX_W'(w_pos - 6'd1);
                    n_k   = '0;
                    case (w_op) inside
                        plt_pkg::OP_GET, plt_pkg::OP_DELETE: begin
                            if (w_rd_ok) begin
                                w_cmd.code = plt_pkg::CMD_LOAD;
                                n_state    = S_SCAN;
                            end else begin
                                w_done       = 1'b1;
                                w_res.status = 1'b1;
                            end
                        end
                        plt_pkg::OP_LOCATE: begin
                            if (r_fill != '0) begin
                                w_cmd.code = plt_pkg::CMD_LOAD;
                                n_state    = S_SCAN;
                            end else begin
                                w_done = 1'b1;
                            end
                        end
                        plt_pkg::OP_INSERT: begin
                            w_done = 1'b1;
                            if (w_ins_ok) begin
                                w_cmd.code  = plt_pkg::CMD_INS;
                                w_cmd.idx   = plt_pkg::IDX_W'(w_pos - 6'd1);
                                w_cmd.value = w_in_val;
                                n_fill      = r_fill + 6'd1;
                            end else begin
                                w_res.status = 1'b1;
                            end
                        end
                        plt_pkg::OP_CLEAR: begin
                            w_done = 1'b1;
                            n_fill = '0;
                        end
                        default: begin
                            w_done       = 1'b1;
                            w_res.status = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // head tap holds entry r_k
                if (r_op == plt_pkg::OP_LOCATE) begin
                    if (w_ctap[0] == r_val) begin
                        w_done      = 1'b1;
                        w_res.found = w_k_next;
                    end else if (w_k_next == r_fill) begin
                        w_done = 1'b1;
                    end else begin
                        w_cmd.code = plt_pkg::CMD_SHIFT;
                        n_k        = w_k_next[plt_pkg::IDX_W-1:0];
                    end
                end else if (r_k == r_idx) begin
                    w_done          = 1'b1;
                    w_res.value_out = w_ctap[0];
                    if (r_op == plt_pkg::OP_DELETE) begin
                        w_cmd.code = plt_pkg::CMD_DEL;
                        n_fill     = r_fill - 6'd1;
                    end
                end else begin
                    w_cmd.code = plt_pkg::CMD_SHIFT;
                    n_k        = w_k_next[plt_pkg::IDX_W-1:0];
                end
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            S_HOLD: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        w_res.fill  = n_fill;
        w_res.empty = (n_fill == '0);
    end

    // hold register for a result that finds the output busy
    always_comb begin
        n_hold_valid = r_hold_valid;
        n_hold       = r_hold;
        if (r_hold_valid && w_slot_free) begin
            n_hold_valid = 1'b0;
        end
        if (w_done && !w_slot_free) begin
            n_hold_valid = 1'b1;
            n_hold       = w_res;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fill       <= '0;
            r_hold_valid <= 1'b0;
        end else begin
            r_state      <= (w_done && !w_slot_free) ? S_HOLD : n_state;
            r_fill       <= n_fill;
            r_hold_valid <= n_hold_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_idx  <= n_idx;
        r_op   <= n_op;
        r_val  <= n_val;
        r_hold <= n_hold;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_slot_free) begin
            r_m_tvalid <= r_hold_valid || w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot_free) begin
            r_m_res <= r_hold_valid ? r_hold : w_res;
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = {3'b000, r_m_res.empty, r_m_res.fill, r_m_res.found,
                            r_m_res.value_out};
    assign m_axis_tuser  = r_m_res.status;

    // row of entry cells
    genvar g;
    generate
        for (g = 0; g < plt_pkg::CAPACITY; g++) begin : g_cell
            if (g == 0) begin : g_first
                assign w_left[g] = '0;
            end else begin : g_inner_l
                assign w_left[g] = w_cval[g-1];
            end
            if (g == plt_pkg::CAPACITY - 1) begin : g_last
                assign w_right[g] = '0;
                assign w_rtap[g]  = '0;
            end else begin : g_inner_r
                assign w_right[g] = w_cval[g+1];
                assign w_rtap[g]  = w_ctap[g+1];
            end
            plt_cell u_cell (
                .i_clk       (i_clk),
                .i_cmd       (w_cmd),
                .i_pos       (plt_pkg::IDX_W'(g)),
                .i_left_val  (w_left[g]),
                .i_right_val (w_right[g]),
                .i_right_tap (w_rtap[g]),
                .o_val       (w_cval[g]),
                .o_tap       (w_ctap[g])
            );
        end
    endgenerate

    // checks
    `PLT_ASSERT_NOW(a_fill_bound, 1'b1, r_fill <= plt_pkg::FILL_W'(plt_pkg::CAPACITY), "fill count above capacity")
    `PLT_ASSERT_NOW(a_hold_needs_out, r_state == S_HOLD, r_m_tvalid && r_hold_valid, "hold state without a waiting result")
    `PLT_ASSERT_NOW(a_scan_in_range, r_state == S_SCAN, ({1'b0, r_k} < r_fill), "scan index beyond fill count")
    `PLT_ASSERT_NEXT(a_insert_grows, w_accept && (w_op == plt_pkg::OP_INSERT) && w_ins_ok, r_fill == $past(r_fill) + 6'd1, "insert did not grow the list")

endmodule

### rtl/core/plt_cell.sv
// ----------------------------------------------------------------------------
// plt_cell
// one list entry with its neighbor shift paths and a read-out tap
// ----------------------------------------------------------------------------
module plt_cell (
    input  logic                       i_clk,
    input  plt_pkg::t_cell_cmd         i_cmd,
    input  logic [plt_pkg::IDX_W-1:0]  i_pos,
    input  logic [plt_pkg::DATA_W-1:0] i_left_val,
    input  logic [plt_pkg::DATA_W-1:0] i_right_val,
    input  logic [plt_pkg::DATA_W-1:0] i_right_tap,
    output logic [plt_pkg::DATA_W-1:0] o_val,
    output logic [plt_pkg::DATA_W-1:0] o_tap
);

    logic [plt_pkg::DATA_W-1:0] r_val;
    logic [plt_pkg::DATA_W-1:0] r_tap;

    // entry update and tap chain
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.code)
            plt_pkg::CMD_INS: begin
                if (i_pos > i_cmd.idx) begin
                    r_val <= i_left_val;
                end else if (i_pos == i_cmd.idx) begin
                    r_val <= i_cmd.value;
                end
            end
            plt_pkg::CMD_DEL: begin
                if (i_pos >= i_cmd.idx) begin
                    r_val <= i_right_val;
                end
            end
            plt_pkg::CMD_LOAD: begin
                r_tap <= r_val;
            end
            plt_pkg::CMD_SHIFT: begin
                r_tap <= i_right_tap;
            end
            default: begin
            end
        endcase
    end

    assign o_val = r_val;
    assign o_tap = r_tap;

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the positional list table: a shadow list in the
// bench predicts every result (status, read value, found position, fill
// level, empty flag), which is compared field by field with each transfer
// on m_axis, under directed, full-list, random and backpressure traffic
// ----------------------------------------------------------------------------
module tb;

    // request codes with no operation behind them
    localparam logic [plt_pkg::OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [plt_pkg::OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [plt_pkg::OP_W-1:0] OP_SPARE_C = 3'd7;

    localparam int RX_HOLD_CYCLES  = 300;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int TAIL_CYCLES     = plt_pkg::CAPACITY + 8;
    localparam int MAX_REPORTS     = 10;
    localparam int RANDOM_ITEMS    = 175;

    localparam logic [plt_pkg::DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [plt_pkg::DATA_W-1:0] VAL_MAX = 32'h7fff_ffff;

    // one result as the block reports it
    typedef struct packed {
        logic                       status;
        logic [plt_pkg::DATA_W-1:0] value_out;
        logic [plt_pkg::POS_W-1:0]  found;
        logic [plt_pkg::FILL_W-1:0] fill;
        logic                       empty;
    } t_list_result;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;    // position[5:0], value[37:6], zero pad
    logic [2:0]  s_axis_tuser  = '0;    // op[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;          // value_out, found_position, fill_level,
                                        // is_empty, zero pad
    logic [0:0]  m_axis_tuser;          // status[0]

    // shadow copy of the list
    logic [plt_pkg::DATA_W-1:0] shadow_entries [plt_pkg::CAPACITY];
    int                         shadow_fill = 0;

    t_list_result pending_results [$];

    int error_count  = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_gen  = 0;
    int rx_hold_seen = 0;
    int rx_hold_left = 0;
    int idle_cycles  = 0;

    positional_list_table DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // apply one request to the shadow list and return its result
    function automatic t_list_result apply_request(
        input logic [plt_pkg::OP_W-1:0]   op,
        input logic [plt_pkg::POS_W-1:0]  pos,
        input logic [plt_pkg::DATA_W-1:0] val);
        t_list_result r;
        int p;
        int k;
        r = '0;
        p = int'(pos);
        case (op)
            plt_pkg::OP_GET: begin
                if (p < 1 || p > shadow_fill) r.status = 1'b1;
                else r.value_out = shadow_entries[p-1];
            end
            plt_pkg::OP_LOCATE: begin
                // walk down so the lowest match is kept
                for (k = shadow_fill - 1; k >= 0; k--)
                    if (shadow_entries[k] == val) r.found = plt_pkg::POS_W'(k + 1);
            end
            plt_pkg::OP_INSERT: begin
                if (shadow_fill >= plt_pkg::CAPACITY || p < 1 || p > shadow_fill + 1) begin
                    r.status = 1'b1;
                end else begin
                    for (k = shadow_fill; k > p - 1; k--)
                        shadow_entries[k] = shadow_entries[k-1];
                    shadow_entries[p-1] = val;
                    shadow_fill++;
                end
            end
            plt_pkg::OP_DELETE: begin
                if (shadow_fill == 0 || p < 1 || p > shadow_fill) begin
                    r.status = 1'b1;
                end else begin
                    r.value_out = shadow_entries[p-1];
                    for (k = p - 1; k + 1 < shadow_fill; k++)
                        shadow_entries[k] = shadow_entries[k+1];
                    shadow_fill--;
                end
            end
            plt_pkg::OP_CLEAR: begin
                shadow_fill = 0;
            end
            default: begin
                r.status = 1'b1;
            end
        endcase
        r.fill  = plt_pkg::FILL_W'(shadow_fill);
        r.empty = (shadow_fill == 0);
        return r;
    endfunction

    // offer one request, record its expected result on transfer
    task automatic send_request(input logic [plt_pkg::OP_W-1:0]   op,
                                input logic [plt_pkg::POS_W-1:0]  pos,
                                input logic [plt_pkg::DATA_W-1:0] val);
        // random gap before the request
        if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, val, pos};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(apply_request(op, pos, val));
    endtask

    // stop offering and wait until every result is in
    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // random request, mostly well-formed against the current list
    task automatic pick_request(output logic [plt_pkg::OP_W-1:0]   op,
                                output logic [plt_pkg::POS_W-1:0]  pos,
                                output logic [plt_pkg::DATA_W-1:0] val);
        int roll;
        roll = $urandom_range(99);
        // value: extremes, a stored entry, or anything
        if (roll < 8) begin
            case ($urandom_range(3))
                0: val = VAL_MIN;
                1: val = VAL_MAX;
                2: val = '0;
                default: val = '1;
            endcase
        end else if (roll < 30 && shadow_fill > 0) begin
            val = shadow_entries[$urandom_range(shadow_fill - 1)];
        end else begin
            val = $urandom;
        end
        roll = $urandom_range(99);
        if (roll < 3) op = plt_pkg::OP_CLEAR;
        else if (roll < 5) op = OP_SPARE_A + plt_pkg::OP_W'($urandom_range(2));
        else if (roll < 37) op = plt_pkg::OP_INSERT;
        else if (roll < 57) op = plt_pkg::OP_DELETE;
        else if (roll < 77) op = plt_pkg::OP_GET;
        else op = plt_pkg::OP_LOCATE;
        // locate mostly looks for something present
        if (op == plt_pkg::OP_LOCATE && shadow_fill > 0 && $urandom_range(99) < 70)
            val = shadow_entries[$urandom_range(shadow_fill - 1)];
        // position: mostly in range, sometimes anything
        if ($urandom_range(99) < 15) begin
            pos = plt_pkg::POS_W'($urandom_range(63));
        end else if (op == plt_pkg::OP_INSERT) begin
            pos = plt_pkg::POS_W'($urandom_range(shadow_fill + 1, 1));
        end else if (op == plt_pkg::OP_GET || op == plt_pkg::OP_DELETE) begin
            pos = plt_pkg::POS_W'(shadow_fill > 0 ? $urandom_range(shadow_fill, 1) : 1);
        end else begin
            pos = plt_pkg::POS_W'($urandom_range(63));
        end
    endtask

    task automatic send_random(input int count);
        logic [plt_pkg::OP_W-1:0]   op;
        logic [plt_pkg::POS_W-1:0]  pos;
        logic [plt_pkg::DATA_W-1:0] val;
        repeat (count) begin
            pick_request(op, pos, val);
            send_request(op, pos, val);
        end
    endtask

    // every operation, bad positions, extremes, spare codes, clear
    task automatic test_directed_cases();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_request(plt_pkg::OP_GET,    6'd1,  '0);        // read on empty list
        send_request(plt_pkg::OP_DELETE, 6'd1,  '0);        // delete on empty list
        send_request(plt_pkg::OP_LOCATE, 6'd0,  '0);
        send_request(plt_pkg::OP_INSERT, 6'd0,  32'd5);     // position zero
        send_request(plt_pkg::OP_INSERT, 6'd2,  32'd5);     // past the end
        send_request(plt_pkg::OP_INSERT, 6'd1,  VAL_MIN);
        send_request(plt_pkg::OP_INSERT, 6'd2,  VAL_MAX);   // append
        send_request(plt_pkg::OP_INSERT, 6'd1,  '1);        // in front
        send_request(plt_pkg::OP_INSERT, 6'd3,  '0);        // in the middle
        send_request(plt_pkg::OP_INSERT, 6'd2,  VAL_MAX);   // duplicate value
        send_request(plt_pkg::OP_LOCATE, 6'd63, VAL_MAX);   // first of two matches
        send_request(plt_pkg::OP_LOCATE, 6'd0,  32'd1234);  // absent
        send_request(plt_pkg::OP_GET,    6'd1,  '0);
        send_request(plt_pkg::OP_GET,    6'd5,  '0);
        send_request(plt_pkg::OP_GET,    6'd6,  '0);        // one past fill
        send_request(plt_pkg::OP_GET,    6'd0,  '0);
        send_request(plt_pkg::OP_DELETE, 6'd63, '1);
        send_request(plt_pkg::OP_DELETE, 6'd3,  '0);        // middle entry
        send_request(plt_pkg::OP_DELETE, 6'd4,  '0);        // last entry
        send_request(OP_SPARE_A,         6'd63, '1);
        send_request(OP_SPARE_B,         6'd1,  VAL_MIN);
        send_request(OP_SPARE_C,         6'd0,  VAL_MAX);
        send_request(plt_pkg::OP_CLEAR,  6'd2,  '0);
        send_request(plt_pkg::OP_GET,    6'd1,  '0);        // read after clear
        send_request(plt_pkg::OP_LOCATE, 6'd1,  '1);        // stale entry not found
        send_request(plt_pkg::OP_CLEAR,  6'd0,  '1);        // clear of empty list
        wait_for_results();
    endtask

    // fill to capacity, overflow, then drain to empty
    task automatic test_full_list();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_request(plt_pkg::OP_CLEAR, 6'd0, '0);
        while (shadow_fill < plt_pkg::CAPACITY)
            send_request(plt_pkg::OP_INSERT,
                         plt_pkg::POS_W'($urandom_range(shadow_fill + 1, 1)), $urandom);
        send_request(plt_pkg::OP_INSERT, 6'd1, VAL_MAX);
        send_request(plt_pkg::OP_INSERT, plt_pkg::POS_W'(plt_pkg::CAPACITY + 1), VAL_MIN);
        send_request(plt_pkg::OP_LOCATE, 6'd0, shadow_entries[plt_pkg::CAPACITY-1]);
        send_request(plt_pkg::OP_GET, plt_pkg::POS_W'(plt_pkg::CAPACITY), '0);
        send_request(plt_pkg::OP_GET, plt_pkg::POS_W'(plt_pkg::CAPACITY + 1), '0);
        while (shadow_fill > 0)
            send_request(plt_pkg::OP_DELETE,
                         plt_pkg::POS_W'($urandom_range(shadow_fill, 1)), $urandom);
        send_request(plt_pkg::OP_DELETE, 6'd1, '0);
        wait_for_results();
    endtask

    // random traffic under one idling setting
    task automatic test_random_mix(input int tx_pct, input int rx_pct);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        send_random(RANDOM_ITEMS);
        wait_for_results();
    endtask

    // receiver holds off for a long stretch while requests keep coming
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_gen++;
        send_random(50);
        wait_for_results();
    endtask

    // result sink: random stalls, or a long hold when one is requested
    always @(posedge i_clk) begin
        if (rx_hold_gen != rx_hold_seen) begin
            rx_hold_seen  <= rx_hold_gen;
            rx_hold_left  <= RX_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left  <= rx_hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // compare each result transfer with the oldest expected result
    always @(posedge i_clk) begin : result_check
        t_list_result want;
        t_list_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status    = m_axis_tuser[0];
            got.value_out = m_axis_tdata[31:0];
            got.found     = m_axis_tdata[37:32];
            got.fill      = m_axis_tdata[43:38];
            got.empty     = m_axis_tdata[44];
            if (pending_results.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result with none pending: status %0d value %h found %0d",
                             $realtime, got.status, got.value_out, got.found);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status || got.value_out !== want.value_out ||
                    got.found !== want.found || got.fill !== want.fill ||
                    got.empty !== want.empty) begin
                    error_count++;
                    if (error_count <= MAX_REPORTS) begin
                        $display("%0t: expected status %0d value %h found %0d fill %0d empty %0d",
                                 $realtime, want.status, want.value_out, want.found,
                                 want.fill, want.empty);
                        $display("%0t: actual   status %0d value %h found %0d fill %0d empty %0d",
                                 $realtime, got.status, got.value_out, got.found,
                                 got.fill, got.empty);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // test sequence
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cases();
        test_full_list();
        test_random_mix(0, 0);
        test_random_mix(48, 0);
        test_random_mix(0, 48);
        test_random_mix(37, 37);
        test_backpressure();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
